// ===== src/scv_pkg.sv =====
// Shared types and constants for the strided multichannel convolution block.
// Used by the sequencer, the multiply-accumulate unit and the top level.
// Depends on nothing else.
package scv_pkg;

  // Widths of the configuration registers and of the item fields.
  localparam int unsigned ImageSideW    = 6;
  localparam int unsigned ChannelCountW = 4;
  localparam int unsigned KernelSideW   = 3;
  localparam int unsigned KernelCountW  = 5;
  localparam int unsigned StepSizeW     = 3;

  localparam int unsigned ModeW       = 2;
  localparam int unsigned StoreIndexW = 13;
  localparam int unsigned SampleW     = 16;
  localparam int unsigned FilterW     = 4;
  localparam int unsigned CoordW      = 5;
  localparam int unsigned ProductW    = 2 * SampleW;
  localparam int unsigned SumW        = 40;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 8;

  // Packed stream widths.
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 40;

  // Reset values of the configuration registers.
  localparam logic [ImageSideW-1:0]    ImageSideRst    = 6'd32;
  localparam logic [ChannelCountW-1:0] ChannelCountRst = 4'd1;
  localparam logic [KernelSideW-1:0]   KernelSideRst   = 3'd3;
  localparam logic [KernelCountW-1:0]  KernelCountRst  = 5'd1;
  localparam logic [StepSizeW-1:0]     StepSizeRst     = 3'd1;

  // Widths of the geometry products formed by the sequencer.
  localparam int unsigned ScaledW   = CoordW + StepSizeW;          // row * step
  localparam int unsigned PlaneW    = 2 * ImageSideW;              // side * side
  localparam int unsigned TapsW     = 2 * KernelSideW;             // kernel taps
  localparam int unsigned RowBaseW  = ScaledW + ImageSideW;
  localparam int unsigned FiltSpanW = ChannelCountW + TapsW;
  localparam int unsigned WBaseW    = FilterW + FiltSpanW;

  typedef enum logic [ModeW-1:0] {
    MODE_LOAD_SAMPLE = 2'd0,
    MODE_LOAD_WEIGHT = 2'd1,
    MODE_COMPUTE     = 2'd2
  } mode_e;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_IMAGE_SIDE    = 3'd0,
    CFG_CHANNEL_COUNT = 3'd1,
    CFG_KERNEL_SIDE   = 3'd2,
    CFG_KERNEL_COUNT  = 3'd3,
    CFG_STEP_SIZE     = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_GRID,
    ST_BASE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } seq_state_e;

  typedef struct packed {
    logic [ImageSideW-1:0]    image_side;
    logic [ChannelCountW-1:0] channel_count;
    logic [KernelSideW-1:0]   kernel_side;
    logic [KernelCountW-1:0]  kernel_count;
    logic [StepSizeW-1:0]     step_size;
  } cfg_t;

  // Controls from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clear;
    logic issue;
  } mac_ctrl_t;

  // Status from the sequencer to the top level.
  typedef struct packed {
    logic idle;
    logic done;
    logic error;
  } seq_res_t;

endpackage

// ===== src/strided_multichannel_convolution.sv =====
// Top level of the strided multichannel 2-D convolution block.
// Depends on scv_pkg, scv_ram, scv_mac and scv_seq.
//
// This block computes one output of a valid (unpadded) strided convolution per
// compute transaction. Load transactions (tuser = load sample or load weight)
// write one signed Q8.8 value into the sample or weight store; an index beyond
// the store is ignored, and the unused mode is dropped without a result. A
// compute transaction names a filter, an output row and an output column and
// produces exactly one result transaction: the Q24.16 sum of weight times
// sample over all channels and taps in tdata with tuser = 0, or a zero sum with
// tuser = 1 when the geometry registers are invalid, the filter is not below
// kernel_count or the request lies outside the output grid. A valid compute
// request is served by the single shared multiply-accumulate unit, which
// consumes one tap per cycle from the two stores. The input stays not ready
// while a compute request is in progress. A finished result waits in an output
// register, so load transactions continue to be accepted while it is not yet
// taken. Configuration writes are always accepted and must only be issued while
// the block is idle. The stores have no reset; reading an entry never written
// gives an undefined sum.
module strided_multichannel_convolution
  import scv_pkg::*;
#(
  parameter int unsigned MAX_SIDE     = 32,
  parameter int unsigned MAX_CHANNELS = 8,
  parameter int unsigned MAX_KERNEL   = 5,
  parameter int unsigned MAX_FILTERS  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write channel.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  // Input stream.
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // tdata from bit 0 up: store_index[12:0], store_value[28:13], out_filter[32:29],
  // out_row[37:33], out_col[42:38], zero fill [47:43].
  input  logic [InDataW-1:0]   s_axis_tdata_i,
  // tuser: mode[1:0].
  input  logic [ModeW-1:0]     s_axis_tuser_i,
  // Output stream.
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // tdata: sum_value[39:0].
  output logic [OutDataW-1:0]  m_axis_tdata_o,
  // tuser: status[0].
  output logic                 m_axis_tuser_o
);

  localparam int unsigned SampleDepth = MAX_CHANNELS * MAX_SIDE * MAX_SIDE;
  localparam int unsigned WeightDepth = MAX_FILTERS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
  localparam int unsigned SampleAw    = (SampleDepth > 1) ? $clog2(SampleDepth) : 1;
  localparam int unsigned WeightAw    = (WeightDepth > 1) ? $clog2(WeightDepth) : 1;

  // Unpacked input fields.
  logic [StoreIndexW-1:0] store_index;
  logic [SampleW-1:0]     store_value;
  logic [FilterW-1:0]     out_filter;
  logic [CoordW-1:0]      out_row;
  logic [CoordW-1:0]      out_col;

  assign store_index = s_axis_tdata_i[12:0];
  assign store_value = s_axis_tdata_i[28:13];
  assign out_filter  = s_axis_tdata_i[32:29];
  assign out_row     = s_axis_tdata_i[37:33];
  assign out_col     = s_axis_tdata_i[42:38];

  // Configuration registers.
  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_SIDE:    cfg_d.image_side    = cfg_data_i[ImageSideW-1:0];
        CFG_CHANNEL_COUNT: cfg_d.channel_count = cfg_data_i[ChannelCountW-1:0];
        CFG_KERNEL_SIDE:   cfg_d.kernel_side   = cfg_data_i[KernelSideW-1:0];
        CFG_KERNEL_COUNT:  cfg_d.kernel_count  = cfg_data_i[KernelCountW-1:0];
        CFG_STEP_SIZE:     cfg_d.step_size     = cfg_data_i[StepSizeW-1:0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_side    <= ImageSideRst;
      cfg_q.channel_count <= ChannelCountRst;
      cfg_q.kernel_side   <= KernelSideRst;
      cfg_q.kernel_count  <= KernelCountRst;
      cfg_q.step_size     <= StepSizeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The geometry is usable when every register is nonzero, each stays within
  // the limits the stores were sized for, and the kernel fits in the image.
  logic geo_ok;

  assign geo_ok = (cfg_q.image_side != '0) && (cfg_q.channel_count != '0)
      && (cfg_q.kernel_side != '0) && (cfg_q.kernel_count != '0)
      && (cfg_q.step_size != '0)
      && (32'(cfg_q.image_side) <= MAX_SIDE)
      && (32'(cfg_q.channel_count) <= MAX_CHANNELS)
      && (32'(cfg_q.kernel_side) <= MAX_KERNEL)
      && (32'(cfg_q.kernel_count) <= MAX_FILTERS)
      && (ImageSideW'(cfg_q.kernel_side) <= cfg_q.image_side);

  // Input handshake and decode.
  seq_res_t seq_res;
  logic     in_accept;
  logic     sample_we;
  logic     weight_we;
  logic     start;

  assign s_axis_tready_o = seq_res.idle;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign sample_we = in_accept && (s_axis_tuser_i == MODE_LOAD_SAMPLE)
      && (32'(store_index) < SampleDepth);
  assign weight_we = in_accept && (s_axis_tuser_i == MODE_LOAD_WEIGHT)
      && (32'(store_index) < WeightDepth);
  assign start     = in_accept && (s_axis_tuser_i == MODE_COMPUTE);

  // Stores and datapath.
  mac_ctrl_t             mac_ctrl;
  logic                  mac_busy;
  logic [SumW-1:0]       mac_acc;
  logic [SampleAw-1:0]   sample_raddr;
  logic [WeightAw-1:0]   weight_raddr;
  logic [SampleW-1:0]    sample_rdata;
  logic [SampleW-1:0]    weight_rdata;
  logic                  out_free;

  scv_ram #(
    .WIDTH (SampleW),
    .DEPTH (SampleDepth)
  ) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (sample_we),
    .waddr_i (SampleAw'(store_index)),
    .wdata_i (store_value),
    .re_i    (mac_ctrl.issue),
    .raddr_i (sample_raddr),
    .rdata_o (sample_rdata)
  );

  scv_ram #(
    .WIDTH (SampleW),
    .DEPTH (WeightDepth)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (weight_we),
    .waddr_i (WeightAw'(store_index)),
    .wdata_i (store_value),
    .re_i    (mac_ctrl.issue),
    .raddr_i (weight_raddr),
    .rdata_o (weight_rdata)
  );

  scv_seq #(
    .SAMPLE_AW (SampleAw),
    .WEIGHT_AW (WeightAw)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .geo_ok_i       (geo_ok),
    .start_i        (start),
    .filter_i       (out_filter),
    .row_i          (out_row),
    .col_i          (out_col),
    .out_free_i     (out_free),
    .mac_busy_i     (mac_busy),
    .mac_ctrl_o     (mac_ctrl),
    .sample_raddr_o (sample_raddr),
    .weight_raddr_o (weight_raddr),
    .res_o          (seq_res)
  );

  scv_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .sample_i (sample_rdata),
    .weight_i (weight_rdata),
    .acc_o    (mac_acc),
    .busy_o   (mac_busy)
  );

  // Output register. It takes a finished result when it is empty or its current
  // content is leaving in this cycle.
  logic            res_valid_q, res_valid_d;
  logic [SumW-1:0] res_sum_q;
  logic            res_status_q;
  logic            res_load;

  assign out_free = !res_valid_q || m_axis_tready_i;
  assign res_load = seq_res.done && out_free;

  always_comb begin
    res_valid_d = res_valid_q;
    if (res_load) begin
      res_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_sum_q    <= seq_res.error ? '0 : mac_acc;
      res_status_q <= seq_res.error;
    end
  end

  assign m_axis_tvalid_o = res_valid_q;
  assign m_axis_tdata_o  = res_sum_q;
  assign m_axis_tuser_o  = res_status_q;

  // A rejected request always carries a zero sum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("error result with nonzero sum");

  // A compute transaction makes the input busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (s_axis_tuser_i == MODE_COMPUTE) |=> !s_axis_tready_o)
    else $error("input ready right after a compute request");

  // The stores are never written while a compute request reads them.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> !(sample_we || weight_we))
    else $error("store written during compute");

  // The accumulator is only cleared once the pipeline from the previous
  // request has drained.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_ctrl.clear |-> !mac_busy)
    else $error("accumulator cleared while products are in flight");

endmodule

// ===== src/scv_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Has no dependencies.
module scv_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/scv_mac.sv =====
// Shared multiply-accumulate unit: one registered Q16.16 product of Q8.8 values per cycle and a
// 40-bit accumulator. Depends on scv_pkg.
module scv_mac
  import scv_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mac_ctrl_t                 ctrl_i,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic signed [SampleW-1:0] weight_i,
  output logic        [SumW-1:0]    acc_o,
  output logic                      busy_o
);

  logic                       data_vld_q;
  logic                       prod_vld_q;
  logic signed [ProductW-1:0] prod_q;
  logic        [SumW-1:0]     acc_q;
  logic        [SumW-1:0]     acc_d;

  // The read data arrives in the cycle after the issue, so the issue flag is delayed
  // to line up with it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_vld_q <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      data_vld_q <= ctrl_i.issue;
      prod_vld_q <= data_vld_q;
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + {{(SumW-ProductW){prod_q[ProductW-1]}}, prod_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_vld_q) begin
      prod_q <= sample_i * weight_i;
    end
    acc_q <= acc_d;
  end

  assign acc_o  = acc_q;
  assign busy_o = data_vld_q | prod_vld_q;

endmodule

// ===== src/scv_seq.sv =====
// Sequencer of the convolution block: checks the request, forms the base
// addresses and walks channels and filter taps one per cycle. Depends on scv_pkg.
module scv_seq
  import scv_pkg::*;
#(
  parameter int unsigned SAMPLE_AW = 13,
  parameter int unsigned WEIGHT_AW = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 geo_ok_i,
  input  logic                 start_i,
  input  logic [FilterW-1:0]   filter_i,
  input  logic [CoordW-1:0]    row_i,
  input  logic [CoordW-1:0]    col_i,
  input  logic                 out_free_i,
  input  logic                 mac_busy_i,
  output mac_ctrl_t            mac_ctrl_o,
  output logic [SAMPLE_AW-1:0] sample_raddr_o,
  output logic [WEIGHT_AW-1:0] weight_raddr_o,
  output seq_res_t             res_o
);

  seq_state_e state_q, state_d;

  logic [FilterW-1:0]       filt_q, filt_d;
  logic [CoordW-1:0]        row_q, row_d;
  logic [CoordW-1:0]        col_q, col_d;
  logic [ScaledW-1:0]       rs_q, rs_d;
  logic [ScaledW-1:0]       cs_q, cs_d;
  logic [PlaneW-1:0]        plane_q, plane_d;
  logic [TapsW-1:0]         taps_q, taps_d;
  logic [RowBaseW-1:0]      row_base_q, row_base_d;
  logic [FiltSpanW-1:0]     span_q, span_d;
  logic [SAMPLE_AW-1:0]     s_addr_q, s_addr_d;
  logic [SAMPLE_AW-1:0]     s_row_q, s_row_d;
  logic [SAMPLE_AW-1:0]     s_chan_q, s_chan_d;
  logic [WEIGHT_AW-1:0]     w_addr_q, w_addr_d;
  logic [KernelSideW-1:0]   kx_q, kx_d;
  logic [KernelSideW-1:0]   ky_q, ky_d;
  logic [ChannelCountW-1:0] ch_q, ch_d;
  logic                     err_q, err_d;

  logic                     grid_bad;
  logic [SAMPLE_AW-1:0]     s_start;
  logic [SAMPLE_AW-1:0]     s_next_row;
  logic [SAMPLE_AW-1:0]     s_next_chan;
  logic [KernelSideW-1:0]   k_last;
  logic [ChannelCountW-1:0] ch_last;
  mac_ctrl_t                mac_ctrl;

  assign k_last  = cfg_i.kernel_side - KernelSideW'(1);
  assign ch_last = cfg_i.channel_count - ChannelCountW'(1);

  // A position is inside the output grid exactly when position * step plus the
  // kernel side still fits in the image, which avoids dividing by the step.
  assign grid_bad = !geo_ok_i
      || ({1'b0, filt_q} >= cfg_i.kernel_count)
      || ((ScaledW+1)'(rs_q) + (ScaledW+1)'(cfg_i.kernel_side)
          > (ScaledW+1)'(cfg_i.image_side))
      || ((ScaledW+1)'(cs_q) + (ScaledW+1)'(cfg_i.kernel_side)
          > (ScaledW+1)'(cfg_i.image_side));

  assign s_start     = SAMPLE_AW'(row_base_q) + SAMPLE_AW'(cs_q);
  assign s_next_row  = s_row_q + SAMPLE_AW'(cfg_i.image_side);
  assign s_next_chan = s_chan_q + SAMPLE_AW'(plane_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    filt_q     <= filt_d;
    row_q      <= row_d;
    col_q      <= col_d;
    rs_q       <= rs_d;
    cs_q       <= cs_d;
    plane_q    <= plane_d;
    taps_q     <= taps_d;
    row_base_q <= row_base_d;
    span_q     <= span_d;
    s_addr_q   <= s_addr_d;
    s_row_q    <= s_row_d;
    s_chan_q   <= s_chan_d;
    w_addr_q   <= w_addr_d;
    kx_q       <= kx_d;
    ky_q       <= ky_d;
    ch_q       <= ch_d;
    err_q      <= err_d;
  end

  always_comb begin
    state_d    = state_q;
    filt_d     = filt_q;
    row_d      = row_q;
    col_d      = col_q;
    rs_d       = rs_q;
    cs_d       = cs_q;
    plane_d    = plane_q;
    taps_d     = taps_q;
    row_base_d = row_base_q;
    span_d     = span_q;
    s_addr_d   = s_addr_q;
    s_row_d    = s_row_q;
    s_chan_d   = s_chan_q;
    w_addr_d   = w_addr_q;
    kx_d       = kx_q;
    ky_d       = ky_q;
    ch_d       = ch_q;
    err_d      = err_q;
    mac_ctrl   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          filt_d  = filter_i;
          row_d   = row_i;
          col_d   = col_i;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        rs_d    = ScaledW'(row_q * cfg_i.step_size);
        cs_d    = ScaledW'(col_q * cfg_i.step_size);
        plane_d = PlaneW'(cfg_i.image_side * cfg_i.image_side);
        taps_d  = TapsW'(cfg_i.kernel_side * cfg_i.kernel_side);
        state_d = ST_GRID;
      end
      ST_GRID: begin
        row_base_d = RowBaseW'(rs_q * cfg_i.image_side);
        span_d     = FiltSpanW'(cfg_i.channel_count * taps_q);
        err_d      = grid_bad;
        state_d    = grid_bad ? ST_DONE : ST_BASE;
      end
      ST_BASE: begin
        s_addr_d       = s_start;
        s_row_d        = s_start;
        s_chan_d       = s_start;
        w_addr_d       = WEIGHT_AW'(WBaseW'(filt_q * span_q));
        kx_d           = '0;
        ky_d           = '0;
        ch_d           = '0;
        mac_ctrl.clear = 1'b1;
        state_d        = ST_RUN;
      end
      ST_RUN: begin
        mac_ctrl.issue = 1'b1;
        w_addr_d       = w_addr_q + WEIGHT_AW'(1);
        if (kx_q != k_last) begin
          kx_d     = kx_q + KernelSideW'(1);
          s_addr_d = s_addr_q + SAMPLE_AW'(1);
        end else if (ky_q != k_last) begin
          kx_d     = '0;
          ky_d     = ky_q + KernelSideW'(1);
          s_row_d  = s_next_row;
          s_addr_d = s_next_row;
        end else if (ch_q != ch_last) begin
          kx_d     = '0;
          ky_d     = '0;
          ch_d     = ch_q + ChannelCountW'(1);
          s_chan_d = s_next_chan;
          s_row_d  = s_next_chan;
          s_addr_d = s_next_chan;
        end else begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!mac_busy_i) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign mac_ctrl_o     = mac_ctrl;
  assign sample_raddr_o = s_addr_q;
  assign weight_raddr_o = w_addr_q;
  assign res_o.idle     = (state_q == ST_IDLE);
  assign res_o.done     = (state_q == ST_DONE);
  assign res_o.error    = err_q;

endmodule
